// ===== rtl/gra_pkg.sv =====
// Shared types and constants for the grid rectangle allocator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package gra_pkg;

    // Field widths of the request and result channels.
    localparam int FIELD_W = 7;
    localparam int OUT_W   = 6;
    localparam int REG_W   = 7;

    // Internal width for row and column arithmetic: holds any size up to 256
    // and any sum of two request fields.
    localparam int CMP_W = 9;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [REG_W-1:0] SIZE_RESET = 7'd64;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        OP_MARK      = 2'd0,
        OP_TEST_OPEN = 2'd1,
        OP_TEST_INCL = 2'd2,
        OP_FIND      = 2'd3
    } opcode_t;

    // Access to the row store, one row word per cycle.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [CMP_W-1:0] row;
    } row_cmd_t;

    // Answer of the run finder: done pulses for one cycle.
    typedef struct packed {
        logic             done;
        logic             hit;
        logic [CMP_W-1:0] pos;
    } run_res_t;

endpackage

`default_nettype wire

// ===== rtl/gra_row_store.sv =====
// Occupancy row store: one row word per address, one read or write per cycle.
// Depends on gra_pkg for the access command type.
`default_nettype none

module gra_row_store #(
    parameter int MAX_ROWS = gra_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gra_pkg::MAX_COLS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gra_pkg::row_cmd_t cmd,
    input  wire logic [MAX_COLS-1:0] wr_data,
    output logic      [MAX_COLS-1:0] rd_data
);

    localparam int ROW_AW = $clog2(MAX_ROWS);

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] q_reg;
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic                rd_valid_reg;
    logic [ROW_AW-1:0]   addr;

    assign addr = cmd.row[ROW_AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            q_reg <= mem[addr];
        end
    end

    // A row never written since reset reads as all free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                row_valid_reg[addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_valid_reg <= row_valid_reg[addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? q_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/gra_run_finder.sv =====
// Run finder: locates the lowest column that starts a run of free columns of a
// given length, using one shared shift-and-AND step per cycle. Depends on gra_pkg.
`default_nettype none

module gra_run_finder #(
    parameter int MAX_COLS = gra_pkg::MAX_COLS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [MAX_COLS-1:0]       free_word,
    input  wire logic [gra_pkg::CMP_W-1:0] need,
    output gra_pkg::run_res_t              res
);

    localparam int CW = gra_pkg::CMP_W;

    typedef enum logic [1:0] {
        R_IDLE,
        R_SHRINK,
        R_ISOLATE,
        R_ENCODE
    } rstate_t;

    rstate_t             state_reg, state_next;
    gra_pkg::run_res_t   res_reg, res_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       gap;
    logic [CW-1:0]       step;
    logic [MAX_COLS-1:0] shifted;
    logic [CW-1:0]       enc;

    // Bit s of cur_reg is set when columns s .. s+len_reg-1 are all free.
    // Each step extends the run length by at most its current value.
    assign gap     = need - len_reg;
    assign step    = (len_reg < gap) ? len_reg : gap;
    assign shifted = cur_reg >> step;

    always_comb begin
        enc = '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            if (cur_reg[i]) begin
                enc = enc | CW'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        len_next      = len_reg;
        res_next      = res_reg;
        res_next.done = 1'b0;
        case (state_reg)
            R_IDLE: begin
                if (start) begin
                    cur_next   = free_word;
                    len_next   = CW'(1);
                    state_next = R_SHRINK;
                end
            end
            R_SHRINK: begin
                if (len_reg >= need) begin
                    state_next = R_ISOLATE;
                end else begin
                    cur_next = cur_reg & shifted;
                    len_next = len_reg + step;
                end
            end
            R_ISOLATE: begin
                cur_next   = cur_reg & (~cur_reg + MAX_COLS'(1));
                state_next = R_ENCODE;
            end
            R_ENCODE: begin
                res_next.done = 1'b1;
                res_next.hit  = |cur_reg;
                res_next.pos  = enc;
                state_next    = R_IDLE;
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            res_reg   <= '0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        len_reg <= len_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/grid_rectangle_allocator.sv =====
// Grid rectangle allocator top level: request decode, row sequencer and result register.
// Depends on gra_pkg, gra_row_store and gra_run_finder.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    opcode, rectangle bounds, block size
//   m_        out        m_valid / m_ready    success, found rectangle corners
//   cfg_      in         cfg_wr_en            cfg_index, cfg_wr_data (grid size)
//
// Steps: a mark or test request reads and then checks each row it covers (S_RECT_RD,
// S_RECT_CHK). A find request, per candidate row, does one store read, one load and
// a search in the run finder; a row with a run then sets up the run's column mask
// and reads and checks the rows below it in turn (S_FIND_CRD, S_FIND_CCHK).
// The single port of the row store and the shared run finder set this pace.
// Reset: synchronous and active low; the grid reads as all free at once, because
// each row carries a valid bit, so there is no clearing pass.
// Stalls: a finished result waits in the output register while the next request
// is taken; a request that finishes while the output is still full waits for it.
`default_nettype none

module grid_rectangle_allocator #(
    parameter int MAX_ROWS = gra_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gra_pkg::MAX_COLS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_wr_en,
    input  wire logic [gra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gra_pkg::REG_W-1:0]     cfg_wr_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_opcode,
    input  wire logic [gra_pkg::FIELD_W-1:0]   s_first_row,
    input  wire logic [gra_pkg::FIELD_W-1:0]   s_first_col,
    input  wire logic [gra_pkg::FIELD_W-1:0]   s_end_row,
    input  wire logic [gra_pkg::FIELD_W-1:0]   s_end_col,
    input  wire logic [gra_pkg::FIELD_W-1:0]   s_block_height,
    input  wire logic [gra_pkg::FIELD_W-1:0]   s_block_width,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_success,
    output logic [gra_pkg::OUT_W-1:0]          m_found_row,
    output logic [gra_pkg::OUT_W-1:0]          m_found_col,
    output logic [gra_pkg::OUT_W-1:0]          m_found_last_row,
    output logic [gra_pkg::OUT_W-1:0]          m_found_last_col
);

    localparam int CW = gra_pkg::CMP_W;
    localparam int OW = gra_pkg::OUT_W;
    localparam logic [CW-1:0] ROWS_LIM = CW'(MAX_ROWS);
    localparam logic [CW-1:0] COLS_LIM = CW'(MAX_COLS);

    // The sequencer walks the grid one row word at a time. Rectangle requests
    // read each row and check it against the column mask (or merge the mask in,
    // for a mark). Find reads a candidate row, hands its free columns to the run
    // finder, and if a run turns up, checks the rows below over that run.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RECT_RD,
        S_RECT_CHK,
        S_FIND_RD,
        S_FIND_LOAD,
        S_FIND_RUN,
        S_FIND_MASK,
        S_FIND_CRD,
        S_FIND_CCHK,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [gra_pkg::REG_W-1:0] rows_in_use_reg;
    logic [gra_pkg::REG_W-1:0] cols_in_use_reg;
    logic [CW-1:0]             rows_eff;
    logic [CW-1:0]             cols_eff;

    // Sequencer registers.
    state_t               state_reg, state_next;
    gra_pkg::opcode_t     op_reg, op_next;
    logic [CW-1:0]        row_cur_reg, row_cur_next;
    logic [CW-1:0]        row_end_reg, row_end_next;
    logic [CW-1:0]        chk_row_reg, chk_row_next;
    logic [CW-1:0]        start_col_reg, start_col_next;
    logic [CW-1:0]        blk_h_reg, blk_h_next;
    logic [CW-1:0]        blk_w_reg, blk_w_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [MAX_COLS-1:0]  mask_reg, mask_next;

    // Finished result, waiting for the output register.
    logic                 res_ok_reg, res_ok_next;
    logic [OW-1:0]        res_row_reg, res_row_next;
    logic [OW-1:0]        res_col_reg, res_col_next;
    logic [OW-1:0]        res_lrow_reg, res_lrow_next;
    logic [OW-1:0]        res_lcol_reg, res_lcol_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic                 m_success_reg, m_success_next;
    logic [OW-1:0]        m_row_reg, m_row_next;
    logic [OW-1:0]        m_col_reg, m_col_next;
    logic [OW-1:0]        m_lrow_reg, m_lrow_next;
    logic [OW-1:0]        m_lcol_reg, m_lcol_next;

    // Request fields widened for arithmetic.
    logic [CW-1:0]        in_r1, in_c1, in_r2, in_c2, in_h, in_w;
    gra_pkg::opcode_t     in_op;

    // Column mask generator, shared by all states that need a column range.
    logic [CW-1:0]        mask_lo, mask_hi;
    logic [MAX_COLS-1:0]  mask_word;

    gra_pkg::row_cmd_t    store_cmd;
    logic [MAX_COLS-1:0]  rd_word;
    logic [MAX_COLS-1:0]  free_word;
    logic                 run_start;
    gra_pkg::run_res_t    run_res;

    logic [CW-1:0]        row_inc;
    logic [CW-1:0]        chk_inc;
    logic [CW-1:0]        row_bottom;
    logic [CW-1:0]        last_row_full;
    logic [CW-1:0]        last_col_full;

    // Combinational control of the finishing paths.
    logic                 fin, fin_ok, fin_found, next_row;

    assign in_op = gra_pkg::opcode_t'(s_opcode);
    assign in_r1 = CW'(s_first_row);
    assign in_c1 = CW'(s_first_col);
    assign in_r2 = CW'(s_end_row);
    assign in_c2 = CW'(s_end_col);
    assign in_h  = CW'(s_block_height);
    assign in_w  = CW'(s_block_width);

    // ------------------------------------------------------------------
    // Configuration. A size of zero acts as one, and a size beyond the
    // storage acts as the storage size.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_in_use_reg <= gra_pkg::SIZE_RESET;
            cols_in_use_reg <= gra_pkg::SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gra_pkg::REG_ROWS_IN_USE: rows_in_use_reg <= cfg_wr_data;
                gra_pkg::REG_COLS_IN_USE: cols_in_use_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rows_in_use_reg == '0) begin
            rows_eff = CW'(1);
        end else if (CW'(rows_in_use_reg) > ROWS_LIM) begin
            rows_eff = ROWS_LIM;
        end else begin
            rows_eff = CW'(rows_in_use_reg);
        end
        if (cols_in_use_reg == '0) begin
            cols_eff = CW'(1);
        end else if (CW'(cols_in_use_reg) > COLS_LIM) begin
            cols_eff = COLS_LIM;
        end else begin
            cols_eff = CW'(cols_in_use_reg);
        end
    end

    // ------------------------------------------------------------------
    // Column mask: bit c is set when mask_lo <= c < mask_hi. At request
    // time it covers the request's columns, when a find row is loaded it
    // covers the search start up to the grid edge, and once a run is found
    // it covers that run.
    // ------------------------------------------------------------------
    always_comb begin
        mask_lo = in_c1;
        mask_hi = (in_op == gra_pkg::OP_TEST_INCL) ? in_c2 + CW'(1) : in_c2;
        case (state_reg)
            S_FIND_LOAD: begin
                mask_lo = start_col_reg;
                mask_hi = cols_eff;
            end
            S_FIND_MASK: begin
                mask_lo = pos_reg;
                mask_hi = pos_reg + blk_w_reg;
            end
            default: ;
        endcase
        for (int c = 0; c < MAX_COLS; c++) begin
            mask_word[c] = (CW'(c) >= mask_lo) && (CW'(c) < mask_hi);
        end
    end

    // ------------------------------------------------------------------
    // Row store and run finder.
    // ------------------------------------------------------------------
    always_comb begin
        store_cmd = '0;
        case (state_reg)
            S_RECT_RD: begin
                store_cmd.rd_en = 1'b1;
                store_cmd.row   = row_cur_reg;
            end
            S_RECT_CHK: begin
                store_cmd.wr_en = (op_reg == gra_pkg::OP_MARK);
                store_cmd.row   = row_cur_reg;
            end
            S_FIND_RD: begin
                store_cmd.rd_en = 1'b1;
                store_cmd.row   = row_cur_reg;
            end
            S_FIND_CRD: begin
                store_cmd.rd_en = 1'b1;
                store_cmd.row   = chk_row_reg;
            end
            default: ;
        endcase
    end

    gra_row_store #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_row_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (store_cmd),
        .wr_data (rd_word | mask_reg),
        .rd_data (rd_word)
    );

    assign free_word = ~rd_word & mask_word;
    assign run_start = (state_reg == S_FIND_LOAD);

    gra_run_finder #(
        .MAX_COLS (MAX_COLS)
    ) u_run_finder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (run_start),
        .free_word (free_word),
        .need      (blk_w_reg),
        .res       (run_res)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign s_ready       = (state_reg == S_IDLE);
    assign row_inc       = row_cur_reg + CW'(1);
    assign chk_inc       = chk_row_reg + CW'(1);
    assign row_bottom    = row_cur_reg + blk_h_reg;
    assign last_row_full = row_bottom - CW'(1);
    assign last_col_full = pos_reg + blk_w_reg - CW'(1);

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_cur_next   = row_cur_reg;
        row_end_next   = row_end_reg;
        chk_row_next   = chk_row_reg;
        start_col_next = start_col_reg;
        blk_h_next     = blk_h_reg;
        blk_w_next     = blk_w_reg;
        pos_next       = pos_reg;
        mask_next      = mask_reg;
        res_ok_next    = res_ok_reg;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_lrow_next  = res_lrow_reg;
        res_lcol_next  = res_lcol_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_success_next = m_success_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_lrow_next    = m_lrow_reg;
        m_lcol_next    = m_lcol_reg;
        fin            = 1'b0;
        fin_ok         = 1'b0;
        fin_found      = 1'b0;
        next_row       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next        = in_op;
                    row_cur_next   = in_r1;
                    start_col_next = in_c1;
                    blk_h_next     = in_h;
                    blk_w_next     = in_w;
                    mask_next      = mask_word;
                    case (in_op)
                        gra_pkg::OP_MARK, gra_pkg::OP_TEST_OPEN: begin
                            row_end_next = in_r2;
                            if (in_r1 > in_r2 || in_c1 > in_c2 ||
                                in_r2 > rows_eff || in_c2 > cols_eff) begin
                                fin = 1'b1;
                            end else if (in_r1 == in_r2) begin
                                // An empty rectangle is trivially marked or free.
                                fin    = 1'b1;
                                fin_ok = 1'b1;
                            end else begin
                                state_next = S_RECT_RD;
                            end
                        end
                        gra_pkg::OP_TEST_INCL: begin
                            row_end_next = in_r2 + CW'(1);
                            if (in_r1 > in_r2 || in_c1 > in_c2 ||
                                in_r2 >= rows_eff || in_c2 >= cols_eff) begin
                                fin = 1'b1;
                            end else begin
                                state_next = S_RECT_RD;
                            end
                        end
                        default: begin
                            if (in_h == '0 || in_w == '0 || in_h > rows_eff ||
                                in_w > cols_eff || in_r1 >= rows_eff) begin
                                fin = 1'b1;
                            end else begin
                                state_next = S_FIND_RD;
                            end
                        end
                    endcase
                end
            end

            S_RECT_RD: begin
                state_next = S_RECT_CHK;
            end

            S_RECT_CHK: begin
                // A mark merges the mask into the row through the store's
                // write port; a test fails on any occupied cell under it.
                if (op_reg != gra_pkg::OP_MARK && (|(rd_word & mask_reg))) begin
                    fin = 1'b1;
                end else begin
                    row_cur_next = row_inc;
                    if (row_inc == row_end_reg) begin
                        fin    = 1'b1;
                        fin_ok = 1'b1;
                    end else begin
                        state_next = S_RECT_RD;
                    end
                end
            end

            S_FIND_RD: begin
                state_next = S_FIND_LOAD;
            end

            S_FIND_LOAD: begin
                state_next = S_FIND_RUN;
            end

            S_FIND_RUN: begin
                if (run_res.done) begin
                    if (run_res.hit && row_bottom <= rows_eff) begin
                        pos_next   = run_res.pos;
                        state_next = S_FIND_MASK;
                    end else begin
                        next_row = 1'b1;
                    end
                end
            end

            S_FIND_MASK: begin
                mask_next    = mask_word;
                chk_row_next = row_inc;
                if (blk_h_reg == CW'(1)) begin
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                    fin_found = 1'b1;
                end else begin
                    state_next = S_FIND_CRD;
                end
            end

            S_FIND_CRD: begin
                state_next = S_FIND_CCHK;
            end

            S_FIND_CCHK: begin
                if (|(rd_word & mask_reg)) begin
                    next_row = 1'b1;
                end else begin
                    chk_row_next = chk_inc;
                    if (chk_inc == row_bottom) begin
                        fin       = 1'b1;
                        fin_ok    = 1'b1;
                        fin_found = 1'b1;
                    end else begin
                        state_next = S_FIND_CRD;
                    end
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_success_next = res_ok_reg;
                    m_row_next     = res_row_reg;
                    m_col_next     = res_col_reg;
                    m_lrow_next    = res_lrow_reg;
                    m_lcol_next    = res_lcol_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Move the find on to the next row, searching it from column zero.
        if (next_row) begin
            row_cur_next   = row_inc;
            start_col_next = '0;
            if (row_inc >= rows_eff) begin
                fin = 1'b1;
            end else begin
                state_next = S_FIND_RD;
            end
        end

        // Every finished request parks its result here; the found corners
        // are zero unless a find succeeded.
        if (fin) begin
            state_next    = S_DONE;
            res_ok_next   = fin_ok;
            res_row_next  = fin_found ? row_cur_reg[OW-1:0]   : '0;
            res_col_next  = fin_found ? pos_reg[OW-1:0]       : '0;
            res_lrow_next = fin_found ? last_row_full[OW-1:0] : '0;
            res_lcol_next = fin_found ? last_col_full[OW-1:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= gra_pkg::OP_MARK;
            row_cur_reg   <= '0;
            row_end_reg   <= '0;
            chk_row_reg   <= '0;
            start_col_reg <= '0;
            blk_h_reg     <= '0;
            blk_w_reg     <= '0;
            pos_reg       <= '0;
            mask_reg      <= '0;
            res_ok_reg    <= 1'b0;
            res_row_reg   <= '0;
            res_col_reg   <= '0;
            res_lrow_reg  <= '0;
            res_lcol_reg  <= '0;
            m_valid_reg   <= 1'b0;
            m_success_reg <= 1'b0;
            m_row_reg     <= '0;
            m_col_reg     <= '0;
            m_lrow_reg    <= '0;
            m_lcol_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            row_cur_reg   <= row_cur_next;
            row_end_reg   <= row_end_next;
            chk_row_reg   <= chk_row_next;
            start_col_reg <= start_col_next;
            blk_h_reg     <= blk_h_next;
            blk_w_reg     <= blk_w_next;
            pos_reg       <= pos_next;
            mask_reg      <= mask_next;
            res_ok_reg    <= res_ok_next;
            res_row_reg   <= res_row_next;
            res_col_reg   <= res_col_next;
            res_lrow_reg  <= res_lrow_next;
            res_lcol_reg  <= res_lcol_next;
            m_valid_reg   <= m_valid_next;
            m_success_reg <= m_success_next;
            m_row_reg     <= m_row_next;
            m_col_reg     <= m_col_next;
            m_lrow_reg    <= m_lrow_next;
            m_lcol_reg    <= m_lcol_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_success        = m_success_reg;
    assign m_found_row      = m_row_reg;
    assign m_found_col      = m_col_reg;
    assign m_found_last_row = m_lrow_reg;
    assign m_found_last_col = m_lcol_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // One request at a time: taking a request closes the input.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while a request was in progress");

    // Only a mark request may change the grid.
    a_write_only_on_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        store_cmd.wr_en |-> (op_reg == gra_pkg::OP_MARK))
        else $error("row store written outside a mark request");

    // A row is checked only right after it was read.
    a_check_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RECT_CHK) |-> ($past(state_reg) == S_RECT_RD))
        else $error("row checked without a preceding read");

    // A failed result carries no rectangle.
    a_fail_has_no_corners: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_success) |-> (m_found_row == '0 && m_found_col == '0 &&
                                     m_found_last_row == '0 && m_found_last_col == '0))
        else $error("failed result with nonzero rectangle corners");

endmodule

`default_nettype wire
